@@ sv/adaptive_baseline_presence_detector_assert.svh @@
// assertion helpers included by the detector rtl file
`ifndef ADAPTIVE_BASELINE_PRESENCE_DETECTOR_ASSERT_SVH
`define ADAPTIVE_BASELINE_PRESENCE_DETECTOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ABPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ABPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/abpd_pkg.sv @@
package abpd_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TIME_W     = 32;
  localparam int PCT_W      = 7;
  localparam int LOCK_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = SAMPLE_W + PCT_W;

  // x/100 as (x*RECIP_100)>>RECIP_SH, exact for any x below 2**PROD_W
  localparam int RECIP_W  = 18;
  localparam int RECIP_SH = 24;
  localparam int SCALE_W  = RECIP_SH + SAMPLE_W;
  localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;

  localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_RST  = 7'd20;
  localparam logic [LOCK_W-1:0] LOCK_RST = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD_PCT = 1'b0,
    CFG_LOCKOUT       = 1'b1
  } cfg_idx_t;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [TIME_W-1:0]   time_ms_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ sv/abpd_if.sv @@
interface abpd_in_if import abpd_pkg::*;;
  logic     valid;
  logic     ready;
  sample_t  sample;
  time_ms_t now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink (input valid, input sample, input now_ms, output ready);
endinterface

interface abpd_out_if import abpd_pkg::*;;
  logic    valid;
  logic    ready;
  logic    detect_event;
  logic    present;
  sample_t baseline;
  sample_t dark_level;

  modport source (output valid, output detect_event, output present, output baseline,
                  output dark_level, input ready);
  modport sink (input valid, input detect_event, input present, input baseline,
                input dark_level, output ready);
endinterface

@@ sv/abpd_ring.sv @@
module abpd_ring import abpd_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output sample_t           rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  sample_t           wr_data
);

  sample_t mem_r [DEPTH];
  sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/abpd_div.sv @@
module abpd_div import abpd_pkg::*; #(
  parameter int DVD_W = 17,
  parameter int DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] diff;
  logic           fits;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign fits   = !diff[DVS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

@@ sv/adaptive_baseline_presence_detector.sv @@
// channel   dir  words                                    handshake
// in_ch     in   sample, now_ms                           valid/ready
// out_ch    out  detect_event, present, baseline, dark    valid/ready
// cfg_*     in   threshold_percent, lockout_ms            write enable, no wait
//
// one word at a time. the dark level is a reciprocal multiply, registered in the
// cycle after the product is. a word left out of the ring passes S_DARK0, S_UPD
// and S_FIN after accept; one that enters the ring also waits in S_MEAN for the
// mean division and recomputes the dark level in S_DARK1 before S_FIN.
// rst_n is synchronous; the ring memory is not cleared, only written entries
// are ever part of the sum. a stalled result holds the sequencer in its last
// state; a new word is taken as soon as the result sits in the output register.
module adaptive_baseline_presence_detector import abpd_pkg::*; #(
  parameter int RING_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  abpd_in_if.sink               in_ch,
  abpd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  `include "adaptive_baseline_presence_detector_assert.svh"

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + SLOT_W;
  localparam int DVD_W  = SUM_W;
  localparam int DVS_W  = CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DARK0,
    S_UPD,
    S_MEAN,
    S_DARK1,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [PCT_W-1:0]  pct_r, pct_nxt;
  logic [LOCK_W-1:0] lockout_r, lockout_nxt;
  sample_t           sample_r, sample_nxt;
  time_ms_t          now_r, now_nxt;
  sample_t           base_r, base_nxt;
  sample_t           dark_r, dark_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              full_r, full_nxt;
  logic              present_r, present_nxt;
  time_ms_t          lock_r, lock_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_detect_r, out_detect_nxt;
  logic              out_present_r, out_present_nxt;
  sample_t           out_base_r, out_base_nxt;
  sample_t           out_dark_r, out_dark_nxt;

  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  div_stat_t         div_stat;
  logic [DVD_W-1:0]  div_quo;
  sample_t           quo10;

  logic              ring_re;
  logic              ring_we;
  sample_t           ring_old;

  logic [PCT_W-1:0]  factor;
  logic [SCALE_W-1:0] scaled;
  sample_t           dark_calc;
  logic [SUM_W:0]    sum_grow;
  logic [SLOT_W-1:0] slot_step;
  logic              full_step;
  logic [CNT_W-1:0]  cnt_step;
  logic              keep;
  logic              is_dark;
  logic              unlocked;
  time_ms_t          elapsed;
  logic              out_free;

  assign quo10    = div_quo[SAMPLE_W-1:0];
  assign factor   = (pct_r >= PCT_FULL) ? '0 : (PCT_FULL - pct_r);
  assign scaled    = SCALE_W'(prod_r) * SCALE_W'(RECIP_100);
  assign dark_calc = scaled[SCALE_W-1:RECIP_SH];
  assign keep     = !(sample_r < dark_r);
  assign sum_grow = {1'b0, sum_r} + (SUM_W+1)'(sample_r)
                    - (full_r ? (SUM_W+1)'(ring_old) : '0);
  assign slot_step = (slot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;
  assign full_step = full_r || (slot_r == SLOT_W'(RING_DEPTH - 1));
  assign cnt_step  = full_step ? CNT_W'(RING_DEPTH) : CNT_W'(slot_step);
  assign is_dark   = sample_r < dark_r;
  assign elapsed   = now_r - lock_r;
  assign unlocked  = elapsed > TIME_W'(lockout_r);
  assign out_free  = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt       = state_r;
    pct_nxt         = pct_r;
    lockout_nxt     = lockout_r;
    sample_nxt      = sample_r;
    now_nxt         = now_r;
    base_nxt        = base_r;
    dark_nxt        = dark_r;
    prod_nxt        = prod_r;
    sum_nxt         = sum_r;
    slot_nxt        = slot_r;
    full_nxt        = full_r;
    present_nxt     = present_r;
    lock_nxt        = lock_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_detect_nxt  = out_detect_r;
    out_present_nxt = out_present_r;
    out_base_nxt    = out_base_r;
    out_dark_nxt    = out_dark_r;
    div_start       = 1'b0;
    div_dvd         = sum_grow[SUM_W-1:0];
    div_dvs         = cnt_step;
    ring_re         = 1'b0;
    ring_we         = 1'b0;

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD_PCT: pct_nxt = cfg_wdata[PCT_W-1:0];
        CFG_LOCKOUT:       lockout_nxt = cfg_wdata[LOCK_W-1:0];
        default:           ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          sample_nxt = in_ch.sample;
          now_nxt    = in_ch.now_ms;
          // dark level against the baseline before this word
          prod_nxt   = PROD_W'(base_r) * PROD_W'(factor);
          // fetch the entry that a write would replace
          ring_re    = 1'b1;
          state_nxt  = S_DARK0;
        end
      end
      S_DARK0: begin
        dark_nxt  = dark_calc;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (keep) begin
          ring_we   = 1'b1;
          sum_nxt   = sum_grow[SUM_W-1:0];
          slot_nxt  = slot_step;
          full_nxt  = full_step;
          div_start = 1'b1;
          state_nxt = S_MEAN;
        end else begin
          // ring untouched, baseline and dark level stand
          state_nxt = S_FIN;
        end
      end
      S_MEAN: begin
        if (div_stat.done) begin
          base_nxt  = quo10;
          prod_nxt  = PROD_W'(quo10) * PROD_W'(factor);
          state_nxt = S_DARK1;
        end
      end
      S_DARK1: begin
        dark_nxt  = dark_calc;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_detect_nxt = 1'b0;
          if (unlocked) begin
            lock_nxt = '0;
            if (is_dark && !present_r) begin
              present_nxt    = 1'b1;
              lock_nxt       = now_r;
              out_detect_nxt = 1'b1;
            end else if (!is_dark && present_r) begin
              present_nxt = 1'b0;
              lock_nxt    = now_r;
            end
          end
          out_valid_nxt   = 1'b1;
          out_present_nxt = present_nxt;
          out_base_nxt    = base_r;
          out_dark_nxt    = dark_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pct_r       <= PCT_RST;
      lockout_r   <= LOCK_RST;
      base_r      <= '0;
      sum_r       <= '0;
      slot_r      <= '0;
      full_r      <= 1'b0;
      present_r   <= 1'b0;
      lock_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pct_r       <= pct_nxt;
      lockout_r   <= lockout_nxt;
      base_r      <= base_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      full_r      <= full_nxt;
      present_r   <= present_nxt;
      lock_r      <= lock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r      <= sample_nxt;
    now_r         <= now_nxt;
    dark_r        <= dark_nxt;
    prod_r        <= prod_nxt;
    out_detect_r  <= out_detect_nxt;
    out_present_r <= out_present_nxt;
    out_base_r    <= out_base_nxt;
    out_dark_r    <= out_dark_nxt;
  end

  abpd_ring #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .rd_en   (ring_re),
    .rd_addr (slot_r),
    .rd_data (ring_old),
    .wr_en   (ring_we),
    .wr_addr (slot_r),
    .wr_data (sample_r)
  );

  abpd_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.detect_event = out_detect_r;
  assign out_ch.present      = out_present_r;
  assign out_ch.baseline     = out_base_r;
  assign out_ch.dark_level   = out_dark_r;

  `ABPD_ASSERT_NEXT(a_one_word_at_a_time, clk, rst_n, in_ch.valid && in_ch.ready,
    !in_ch.ready, "input taken again while a word is in flight")
  `ABPD_ASSERT_NOW(a_div_no_restart, clk, rst_n, div_start, !div_stat.busy,
    "divider restarted while busy")
  `ABPD_ASSERT_NOW(a_ring_write_timing, clk, rst_n, ring_we,
    state_r == S_UPD && keep, "ring written outside the update step")
  `ABPD_ASSERT_NOW(a_detect_sets_present, clk, rst_n, out_ch.valid && out_ch.detect_event,
    out_ch.present, "detect pulse without presence")
  `ABPD_ASSERT_NOW(a_slot_in_range, clk, rst_n, 1'b1, slot_r <= SLOT_W'(RING_DEPTH - 1),
    "write slot beyond ring depth")

endmodule

@@ bench/tb_adaptive_baseline_presence_detector.sv @@
module tb_adaptive_baseline_presence_detector;
  import abpd_pkg::*;

  localparam int RING_SLOTS = 16;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_WORDS = 240;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic    detect_event;
    logic    present;
    sample_t baseline;
    sample_t dark_level;
  } report_t;

  typedef struct packed {
    sample_t  sample;
    time_ms_t now_ms;
    logic     known;
    report_t  report;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  abpd_in_if  in_ch ();
  abpd_out_if out_ch ();

  adaptive_baseline_presence_detector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // detector state as the block should hold it
  sample_t        ring_q [RING_SLOTS];
  logic [3:0]     slot;
  logic           ring_full;
  logic           present_flag;
  time_ms_t       lock_start;
  logic [PCT_W-1:0]  pct;
  logic [LOCK_W-1:0] hold_ms;

  report_t pending_reports [$];
  report_t want;
  int mismatches = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  function automatic sample_t ring_avg();
    int count;
    int sum;
    count = ring_full ? RING_SLOTS : int'(slot);
    sum = 0;
    if (count == 0) return '0;
    for (int i = 0; i < count; i++) sum += int'(ring_q[i]);
    return sample_t'(sum / count);
  endfunction

  function automatic sample_t dark_from(sample_t b);
    if (pct >= PCT_FULL) return '0;
    return sample_t'((int'(b) * (100 - int'(pct))) / 100);
  endfunction

  function automatic report_t detect_step(sample_t s, time_ms_t t);
    sample_t b;
    logic is_dark;
    report_t r;
    r.detect_event = 1'b0;
    // ring takes the word unless it is dark against the old baseline
    b = ring_avg();
    if (!(s < dark_from(b))) begin
      ring_q[slot] = s;
      slot = slot + 4'd1;
      if (slot == 4'd0) ring_full = 1'b1;
    end
    b = ring_avg();
    r.dark_level = dark_from(b);
    r.baseline = b;
    is_dark = s < r.dark_level;
    if (time_ms_t'(t - lock_start) > {16'd0, hold_ms}) begin
      lock_start = '0;
      if (is_dark && !present_flag) begin
        present_flag = 1'b1;
        lock_start = t;
        r.detect_event = 1'b1;
      end else if (!is_dark && present_flag) begin
        present_flag = 1'b0;
        lock_start = t;
      end
    end
    r.present = present_flag;
    return r;
  endfunction

  function automatic sample_t pick_sample(bit occupied);
    sample_t b;
    sample_t lvl;
    int roll;
    int v;
    b = ring_avg();
    lvl = dark_from(b);
    roll = $urandom_range(0, 99);
    if (roll < 10) return sample_t'($urandom_range(0, 1023));
    if (roll < 14) return lvl;
    if (occupied && lvl > 0) return sample_t'($urandom_range(0, int'(lvl) - 1));
    if (b == 0) return sample_t'($urandom_range(300, 1023));
    v = int'(b) + int'($urandom_range(0, 80)) - 40;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return sample_t'(v);
  endfunction

  function automatic time_ms_t next_time(time_ms_t t);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return time_ms_t'($urandom);
    if (roll < 8) return t;
    return t + time_ms_t'($urandom_range(1, 2 * int'(hold_ms) + 2));
  endfunction

  task automatic push_word(sample_t s, time_ms_t t, logic known, report_t typed);
    report_t r;
    while (!no_gaps && $urandom_range(0, 99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.now_ms <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = detect_step(s, t);
    pending_reports.push_back(known ? typed : r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THRESHOLD_PCT) pct = val[PCT_W-1:0];
    else hold_ms = val[LOCK_W-1:0];
  endtask

  task automatic check_field(string what, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d, actual %0d", $time, what, exp_v, got_v);
      mismatches++;
    end
  endtask

  // receiver stalls
  always @(posedge clk) out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 7);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual baseline %0d", $time,
                 out_ch.baseline);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("detect_event", want.detect_event, out_ch.detect_event);
        check_field("present", want.present, out_ch.present);
        check_field("baseline", want.baseline, out_ch.baseline);
        check_field("dark_level", want.dark_level, out_ch.dark_level);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t rows [0:22];
    int phase_pct [NUM_PHASES];
    int phase_lock [NUM_PHASES];
    time_ms_t t;
    bit occupied;

    rows = '{
      // empty ring, still inside the window that follows reset
      '{10'd1023, 32'd0,    1'b1, '{1'b0, 1'b0, 10'd1023, 10'd818}},
      '{10'd0,    32'd1000, 1'b1, '{1'b1, 1'b1, 10'd1023, 10'd818}},
      // exactly at the end of the lockout window
      '{10'd0,    32'd1500, 1'b1, '{1'b0, 1'b1, 10'd1023, 10'd818}},
      '{10'd1023, 32'd1501, 1'b1, '{1'b0, 1'b0, 10'd1023, 10'd818}},
      // fill the ring until it wraps, first one right at the dark level
      '{10'd818,  32'd2000, 1'b0, '0},
      '{10'd1023, 32'd2100, 1'b0, '0},
      '{10'd900,  32'd2200, 1'b0, '0},
      '{10'd1000, 32'd2300, 1'b0, '0},
      '{10'd850,  32'd2400, 1'b0, '0},
      '{10'd950,  32'd2500, 1'b0, '0},
      '{10'd820,  32'd2600, 1'b0, '0},
      '{10'd999,  32'd2700, 1'b0, '0},
      '{10'd870,  32'd2800, 1'b0, '0},
      '{10'd1010, 32'd2900, 1'b0, '0},
      '{10'd940,  32'd3000, 1'b0, '0},
      '{10'd830,  32'd3100, 1'b0, '0},
      '{10'd960,  32'd3200, 1'b0, '0},
      '{10'd1020, 32'd3300, 1'b0, '0},
      // lockout across the timestamp wrap
      '{10'd0,    32'hFFFF_FFFF, 1'b0, '0},
      '{10'd1023, 32'h0000_01F3, 1'b0, '0},
      '{10'd1023, 32'h0000_01F4, 1'b0, '0},
      '{10'd512,  32'h8000_0000, 1'b0, '0},
      '{10'd0,    32'hFFFF_FC00, 1'b0, '0}
    };
    phase_pct  = '{20, 0, 100, 127, 1, 99, 0, 50};
    phase_lock = '{500, 0, 65535, 0, 1, 300, 0, 65534};
    phase_pct[6]  = $urandom_range(0, 127);
    phase_lock[6] = $urandom_range(0, 65535);

    foreach (ring_q[i]) ring_q[i] = '0;
    slot = '0;
    ring_full = 1'b0;
    present_flag = 1'b0;
    lock_start = '0;
    pct = PCT_RST;
    hold_ms = LOCK_RST;

    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    in_ch.now_ms <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_THRESHOLD_PCT;
    cfg_wdata    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) push_word(rows[i].sample, rows[i].now_ms, rows[i].known, rows[i].report);

    t = 32'h0001_0000;
    occupied = 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(CFG_THRESHOLD_PCT, CFG_DATA_W'(phase_pct[p]));
      write_reg(CFG_LOCKOUT, CFG_DATA_W'(phase_lock[p]));
      no_gaps = (p == 3);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) < 6) occupied = !occupied;
        t = next_time(t);
        push_word(pick_sample(occupied), t, 1'b0, '0);
      end
    end
    no_gaps = 1'b0;

    drain();
    repeat (80) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/abpd_pkg.sv
sv/abpd_if.sv
sv/abpd_ring.sv
sv/abpd_div.sv
sv/adaptive_baseline_presence_detector.sv
bench/tb_adaptive_baseline_presence_detector.sv
